// ===== rtl/quintic_trajectory_generator_unit_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef QUINTIC_TRAJECTORY_GENERATOR_UNIT_ASSERT_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define QTG_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("qtg: same-cycle check failed");

// next-cycle implication
`define QTG_ASSERT_NXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("qtg: next-cycle check failed");

`endif

// ===== rtl/qtg_pkg.sv =====
package qtg_pkg;

   localparam int COEFF_WIDTH = 48;
   localparam int FRAC_BITS   = 16;

   // coefficient arithmetic headroom
   localparam int EXT_W = (COEFF_WIDTH > 56) ? COEFF_WIDTH + 2 : 58;
   // divider dividend width: duration (length << 16) or phase (elapsed << FRAC_BITS)
   localparam int DIV_W = (32 + FRAC_BITS > 49) ? 32 + FRAC_BITS : 49;
   localparam int CNT_W = $clog2(DIV_W);
   localparam int ROOT_STEPS = 32;
   localparam int NUM_COEF   = 6;

   localparam logic [30:0] SPEED_RESET  = 31'd65536;
   localparam logic [30:0] PERIOD_RESET = 31'd2621;

   localparam logic REG_SPEED  = 1'b0;
   localparam logic REG_PERIOD = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef logic signed [COEFF_WIDTH-1:0] coef_type;
   typedef logic signed [EXT_W-1:0]       ext_type;
   typedef logic signed [COEFF_WIDTH:0]   hprod_type;
   typedef logic [FRAC_BITS-1:0]          frac_type;
   typedef logic [DIV_W-1:0]              div_type;
   typedef logic [CNT_W-1:0]              cnt_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SQ, S_ROOT_INIT, S_ROOT, S_DDIV_INIT, S_DIV, S_DUR, S_WMUL,
      S_COEF, S_LRES, S_TICK, S_TCHK, S_SDIV_INIT, S_H_INIT, S_H_MUL, S_H_ADD,
      S_H_FIN, S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_CAPTURE, CMD_SQ, CMD_ROOT_INIT, CMD_ROOT_STEP, CMD_DDIV_INIT,
      CMD_SDIV_INIT, CMD_DIV_STEP, CMD_DUR, CMD_WMUL, CMD_COEF, CMD_LRES,
      CMD_TICK_ADD, CMD_TCHK, CMD_H_INIT, CMD_H_MUL, CMD_H_ADD, CMD_H_FIN, CMD_EMIT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic        axis;
      logic [2:0]  idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic live;
   } status_type;

endpackage

// ===== rtl/qtg_ctrl.sv =====
module qtg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  qtg_pkg::status_type  status,
   output qtg_pkg::cmd_type     cmd
);

   qtg_pkg::state_type state_ff, state_in;
   qtg_pkg::cnt_type   cnt_ff, cnt_in;
   logic               axis_ff, axis_in;
   logic               tick_ff, tick_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qtg_pkg::S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
         tick_ff  <= tick_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      tick_in  = tick_ff;
      unique case (state_ff)
         qtg_pkg::S_IDLE: begin
            if (req_valid) begin
               cnt_in  = '0;
               axis_in = 1'b0;
               tick_in = (req_op == qtg_pkg::OP_TICK);
               state_in = (req_op == qtg_pkg::OP_TICK) ? qtg_pkg::S_TICK : qtg_pkg::S_SQ;
            end
         end
         qtg_pkg::S_SQ: begin
            if (cnt_ff[0]) begin
               cnt_in   = '0;
               state_in = qtg_pkg::S_ROOT_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qtg_pkg::S_ROOT_INIT: begin
            cnt_in   = '0;
            state_in = qtg_pkg::S_ROOT;
         end
         qtg_pkg::S_ROOT: begin
            if (cnt_ff == qtg_pkg::cnt_type'(qtg_pkg::ROOT_STEPS - 1)) begin
               state_in = qtg_pkg::S_DDIV_INIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qtg_pkg::S_DDIV_INIT, qtg_pkg::S_SDIV_INIT: begin
            cnt_in   = '0;
            state_in = qtg_pkg::S_DIV;
         end
         qtg_pkg::S_DIV: begin
            if (cnt_ff == qtg_pkg::cnt_type'(qtg_pkg::DIV_W - 1)) begin
               cnt_in   = '0;
               axis_in  = 1'b0;
               state_in = tick_ff ? qtg_pkg::S_H_INIT : qtg_pkg::S_DUR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qtg_pkg::S_DUR: begin
            cnt_in   = '0;
            state_in = qtg_pkg::S_WMUL;
         end
         qtg_pkg::S_WMUL: begin
            if (cnt_ff == qtg_pkg::cnt_type'(3)) begin
               cnt_in   = '0;
               axis_in  = 1'b0;
               state_in = qtg_pkg::S_COEF;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qtg_pkg::S_COEF: begin
            if (cnt_ff == qtg_pkg::cnt_type'(qtg_pkg::NUM_COEF - 1)) begin
               cnt_in  = '0;
               axis_in = 1'b1;
               if (axis_ff) state_in = qtg_pkg::S_LRES;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         qtg_pkg::S_LRES: state_in = qtg_pkg::S_EMIT;
         qtg_pkg::S_TICK: state_in = qtg_pkg::S_TCHK;
         qtg_pkg::S_TCHK: begin
            state_in = status.live ? qtg_pkg::S_SDIV_INIT : qtg_pkg::S_EMIT;
         end
         qtg_pkg::S_H_INIT: begin
            cnt_in   = qtg_pkg::cnt_type'(qtg_pkg::NUM_COEF - 2);
            state_in = qtg_pkg::S_H_MUL;
         end
         qtg_pkg::S_H_MUL: state_in = qtg_pkg::S_H_ADD;
         qtg_pkg::S_H_ADD: begin
            if (cnt_ff == '0) begin
               state_in = qtg_pkg::S_H_FIN;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = qtg_pkg::S_H_MUL;
            end
         end
         qtg_pkg::S_H_FIN: begin
            if (axis_ff) begin
               state_in = qtg_pkg::S_EMIT;
            end else begin
               axis_in  = 1'b1;
               state_in = qtg_pkg::S_H_INIT;
            end
         end
         qtg_pkg::S_EMIT: begin
            if (status.out_free) state_in = qtg_pkg::S_IDLE;
         end
         default: state_in = qtg_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = qtg_pkg::CMD_NONE;
      cmd.axis  = axis_ff;
      cmd.idx   = cnt_ff[2:0];
      unique case (state_ff)
         qtg_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = qtg_pkg::CMD_CAPTURE;
         end
         qtg_pkg::S_SQ: begin
            cmd.op   = qtg_pkg::CMD_SQ;
            cmd.axis = cnt_ff[0];
         end
         qtg_pkg::S_ROOT_INIT: cmd.op = qtg_pkg::CMD_ROOT_INIT;
         qtg_pkg::S_ROOT:      cmd.op = qtg_pkg::CMD_ROOT_STEP;
         qtg_pkg::S_DDIV_INIT: cmd.op = qtg_pkg::CMD_DDIV_INIT;
         qtg_pkg::S_SDIV_INIT: cmd.op = qtg_pkg::CMD_SDIV_INIT;
         qtg_pkg::S_DIV:       cmd.op = qtg_pkg::CMD_DIV_STEP;
         qtg_pkg::S_DUR:       cmd.op = qtg_pkg::CMD_DUR;
         qtg_pkg::S_WMUL: begin
            cmd.op   = qtg_pkg::CMD_WMUL;
            cmd.axis = cnt_ff[1];
            cmd.idx  = {2'b00, cnt_ff[0]};
         end
         qtg_pkg::S_COEF:     cmd.op = qtg_pkg::CMD_COEF;
         qtg_pkg::S_LRES:     cmd.op = qtg_pkg::CMD_LRES;
         qtg_pkg::S_TICK:     cmd.op = qtg_pkg::CMD_TICK_ADD;
         qtg_pkg::S_TCHK:     cmd.op = qtg_pkg::CMD_TCHK;
         qtg_pkg::S_H_INIT: begin
            cmd.op  = qtg_pkg::CMD_H_INIT;
            cmd.idx = 3'(qtg_pkg::NUM_COEF - 1);
         end
         qtg_pkg::S_H_MUL:    cmd.op = qtg_pkg::CMD_H_MUL;
         qtg_pkg::S_H_ADD:    cmd.op = qtg_pkg::CMD_H_ADD;
         qtg_pkg::S_H_FIN:    cmd.op = qtg_pkg::CMD_H_FIN;
         qtg_pkg::S_EMIT: begin
            if (status.out_free) cmd.op = qtg_pkg::CMD_EMIT;
         end
         default: cmd.op = qtg_pkg::CMD_NONE;
      endcase
   end

endmodule

// ===== rtl/qtg_datapath.sv =====
module qtg_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  qtg_pkg::cmd_type     cmd,
   output qtg_pkg::status_type  status,
   input  logic [255:0]         req_tdata,
   input  logic [30:0]          speed,
   input  logic [30:0]          period,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser
);

   // segment inputs
   logic signed [31:0] bx_ff, by_ff, ex_ff, ey_ff, v0x_ff, v0y_ff, v1x_ff, v1y_ff;
   // length and divider
   logic [64:0]        sum_ff;
   logic [63:0]        rad_ff;
   logic               big_ff;
   logic [33:0]        rrem_ff;
   logic [31:0]        root_ff;
   qtg_pkg::div_type   dnum_ff;
   logic [31:0]        drem_ff, dden_ff;
   // control state
   logic [31:0]        duration_ff, elapsed_ff;
   logic               seg_clip_ff, flag_ff;
   // coefficients and evaluation
   logic signed [47:0] w0x_ff, wmx_ff, w0y_ff, wmy_ff;
   qtg_pkg::coef_type  cx_ff [qtg_pkg::NUM_COEF];
   qtg_pkg::coef_type  cy_ff [qtg_pkg::NUM_COEF];
   qtg_pkg::coef_type  acc_ff;
   qtg_pkg::hprod_type prod_ff;
   // result staging and output register
   logic [31:0]        res_x_ff, res_y_ff;
   logic               res_done_ff, res_flag_ff;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   function automatic logic ovf_c(input qtg_pkg::ext_type v);
      qtg_pkg::coef_type t;
      t = v[qtg_pkg::COEFF_WIDTH-1:0];
      return qtg_pkg::ext_type'(t) != v;
   endfunction

   function automatic qtg_pkg::coef_type sat_c(input qtg_pkg::ext_type v);
      qtg_pkg::coef_type r;
      r = v[qtg_pkg::COEFF_WIDTH-1:0];
      if (ovf_c(v)) r = v[qtg_pkg::EXT_W-1] ? {1'b1, {(qtg_pkg::COEFF_WIDTH-1){1'b0}}}
                                           : {1'b0, {(qtg_pkg::COEFF_WIDTH-1){1'b1}}};
      return r;
   endfunction

   // differences and magnitudes
   logic signed [32:0] dx, dy, dsel, vsum_x, vsum_y;
   logic [31:0]        ax, ay;
   assign dx = {ex_ff[31], ex_ff} - {bx_ff[31], bx_ff};
   assign dy = {ey_ff[31], ey_ff} - {by_ff[31], by_ff};
   assign ax = dx[32] ? 32'(-dx) : dx[31:0];
   assign ay = dy[32] ? 32'(-dy) : dy[31:0];
   assign vsum_x = {v0x_ff[31], v0x_ff} + {v1x_ff[31], v1x_ff};
   assign vsum_y = {v0y_ff[31], v0y_ff} + {v1y_ff[31], v1y_ff};
   assign dsel = cmd.axis ? dy : dx;

   // shared 33x33 multiplier: squares and velocity times duration
   logic signed [31:0] vsel;
   logic signed [32:0] ma, mb;
   logic signed [65:0] mp;
   always_comb begin
      unique case ({cmd.axis, cmd.idx[0]})
         2'b00:   vsel = v0x_ff;
         2'b01:   vsel = vsum_x[32:1];
         2'b10:   vsel = v0y_ff;
         default: vsel = vsum_y[32:1];
      endcase
      if (cmd.op == qtg_pkg::CMD_SQ) begin
         ma = {1'b0, cmd.axis ? ay : ax};
         mb = ma;
      end else begin
         ma = {vsel[31], vsel};
         mb = {1'b0, duration_ff};
      end
   end
   assign mp = ma * mb;

   // root digit step
   logic [35:0] rr, rtrial;
   logic        rge;
   assign rr     = {rrem_ff, rad_ff[63:62]};
   assign rtrial = {2'b00, root_ff, 2'b01};
   assign rge    = rr >= rtrial;

   // divider step
   logic [32:0] dr;
   logic        dge;
   assign dr  = {drem_ff, dnum_ff[qtg_pkg::DIV_W-1]};
   assign dge = dr >= {1'b0, dden_ff};

   logic [32:0] len;
   assign len = big_ff ? {root_ff, 1'b0} : {1'b0, root_ff};

   // coefficient formation
   qtg_pkg::ext_type de, w0e, wme, craw;
   assign de  = qtg_pkg::ext_type'(dsel);
   assign w0e = qtg_pkg::ext_type'(cmd.axis ? w0y_ff : w0x_ff);
   assign wme = qtg_pkg::ext_type'(cmd.axis ? wmy_ff : wmx_ff);
   always_comb begin
      unique case (cmd.idx)
         3'd0:    craw = qtg_pkg::ext_type'(cmd.axis ? by_ff : bx_ff);
         3'd1:    craw = w0e;
         3'd3:    craw = de * qtg_pkg::ext_type'(10) - w0e * qtg_pkg::ext_type'(6)
                         - wme * qtg_pkg::ext_type'(4);
         3'd4:    craw = w0e * qtg_pkg::ext_type'(8) + wme * qtg_pkg::ext_type'(7)
                         - de * qtg_pkg::ext_type'(15);
         3'd5:    craw = de * qtg_pkg::ext_type'(6) - w0e * qtg_pkg::ext_type'(3)
                         - wme * qtg_pkg::ext_type'(3);
         default: craw = '0;
      endcase
   end
   logic zero_dur, ckeep;
   assign zero_dur = duration_ff == '0;
   assign ckeep    = (cmd.idx == 3'd0) || !zero_dur;

   // horner step: |acc| * s, truncated toward zero
   qtg_pkg::frac_type s;
   logic [qtg_pkg::COEFF_WIDTH-1:0] hm, pa;
   logic [qtg_pkg::COEFF_WIDTH+qtg_pkg::FRAC_BITS-1:0] pm;
   qtg_pkg::coef_type csel;
   qtg_pkg::ext_type  hsum;
   assign s    = dnum_ff[qtg_pkg::FRAC_BITS-1:0];
   assign hm   = acc_ff[qtg_pkg::COEFF_WIDTH-1] ? -acc_ff : acc_ff;
   assign pm   = hm * s;
   assign pa   = pm[qtg_pkg::COEFF_WIDTH+qtg_pkg::FRAC_BITS-1:qtg_pkg::FRAC_BITS];
   assign csel = cmd.axis ? cy_ff[cmd.idx] : cx_ff[cmd.idx];
   assign hsum = qtg_pkg::ext_type'(csel) + qtg_pkg::ext_type'(prod_ff);

   // final 32-bit saturation
   logic signed [31:0] acc32, fin;
   logic               fovf;
   assign acc32 = acc_ff[31:0];
   assign fovf  = qtg_pkg::coef_type'(acc32) != acc_ff;
   assign fin   = fovf ? (acc_ff[qtg_pkg::COEFF_WIDTH-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                       : acc32;

   logic [32:0] esum;
   assign esum = {1'b0, elapsed_ff} + {2'b00, period};

   assign status.live     = elapsed_ff < duration_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff  <= '0;
         elapsed_ff   <= '0;
         seg_clip_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == qtg_pkg::CMD_DUR) begin
            duration_ff <= (|dnum_ff[qtg_pkg::DIV_W-1:32]) ? '1 : dnum_ff[31:0];
            elapsed_ff  <= '0;
         end
         if (cmd.op == qtg_pkg::CMD_TICK_ADD) elapsed_ff <= esum[32] ? '1 : esum[31:0];
         if (cmd.op == qtg_pkg::CMD_LRES) seg_clip_ff <= flag_ff;
         if (cmd.op == qtg_pkg::CMD_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)             rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         qtg_pkg::CMD_CAPTURE: begin
            bx_ff  <= req_tdata[31:0];
            by_ff  <= req_tdata[63:32];
            ex_ff  <= req_tdata[95:64];
            ey_ff  <= req_tdata[127:96];
            v0x_ff <= req_tdata[159:128];
            v0y_ff <= req_tdata[191:160];
            v1x_ff <= req_tdata[223:192];
            v1y_ff <= req_tdata[255:224];
            flag_ff <= 1'b0;
         end
         qtg_pkg::CMD_SQ: begin
            if (cmd.axis) sum_ff <= sum_ff + {1'b0, mp[63:0]};
            else          sum_ff <= {1'b0, mp[63:0]};
         end
         qtg_pkg::CMD_ROOT_INIT: begin
            rad_ff  <= sum_ff[64] ? {1'b0, sum_ff[64:2]} : sum_ff[63:0];
            big_ff  <= sum_ff[64];
            rrem_ff <= '0;
            root_ff <= '0;
         end
         qtg_pkg::CMD_ROOT_STEP: begin
            rad_ff  <= {rad_ff[61:0], 2'b00};
            rrem_ff <= rge ? 34'(rr - rtrial) : rr[33:0];
            root_ff <= {root_ff[30:0], rge};
         end
         qtg_pkg::CMD_DDIV_INIT: begin
            dnum_ff <= qtg_pkg::div_type'({len, 16'h0000});
            dden_ff <= (speed == '0) ? 32'd1 : {1'b0, speed};
            drem_ff <= '0;
         end
         qtg_pkg::CMD_SDIV_INIT: begin
            dnum_ff <= qtg_pkg::div_type'({elapsed_ff, {qtg_pkg::FRAC_BITS{1'b0}}});
            dden_ff <= duration_ff;
            drem_ff <= '0;
         end
         qtg_pkg::CMD_DIV_STEP: begin
            dnum_ff <= {dnum_ff[qtg_pkg::DIV_W-2:0], dge};
            drem_ff <= dge ? 32'(dr - {1'b0, dden_ff}) : dr[31:0];
         end
         qtg_pkg::CMD_WMUL: begin
            unique case ({cmd.axis, cmd.idx[0]})
               2'b00:   w0x_ff <= mp[63:16];
               2'b01:   wmx_ff <= mp[63:16];
               2'b10:   w0y_ff <= mp[63:16];
               default: wmy_ff <= mp[63:16];
            endcase
         end
         qtg_pkg::CMD_COEF: begin
            if (cmd.axis) cy_ff[cmd.idx] <= ckeep ? sat_c(craw) : '0;
            else          cx_ff[cmd.idx] <= ckeep ? sat_c(craw) : '0;
            if (ckeep && cmd.idx != 3'd0 && ovf_c(craw)) flag_ff <= 1'b1;
         end
         qtg_pkg::CMD_LRES: begin
            res_x_ff    <= bx_ff;
            res_y_ff    <= by_ff;
            res_done_ff <= 1'b0;
            res_flag_ff <= flag_ff;
         end
         qtg_pkg::CMD_TCHK: begin
            flag_ff <= seg_clip_ff;
            if (!status.live) begin
               res_x_ff    <= '0;
               res_y_ff    <= '0;
               res_done_ff <= 1'b1;
               res_flag_ff <= 1'b0;
            end
         end
         qtg_pkg::CMD_H_INIT: acc_ff <= csel;
         qtg_pkg::CMD_H_MUL: begin
            prod_ff <= acc_ff[qtg_pkg::COEFF_WIDTH-1] ? -qtg_pkg::hprod_type'(pa)
                                                     : qtg_pkg::hprod_type'(pa);
         end
         qtg_pkg::CMD_H_ADD: begin
            acc_ff <= sat_c(hsum);
            if (ovf_c(hsum)) flag_ff <= 1'b1;
         end
         qtg_pkg::CMD_H_FIN: begin
            if (cmd.axis) res_y_ff <= fin;
            else          res_x_ff <= fin;
            res_done_ff <= 1'b0;
            res_flag_ff <= flag_ff || fovf;
            if (fovf) flag_ff <= 1'b1;
         end
         qtg_pkg::CMD_EMIT: begin
            rsp_data_ff <= {res_y_ff, res_x_ff};
            rsp_user_ff <= {res_flag_ff, res_done_ff};
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/quintic_trajectory_generator_unit.sv =====
// load transaction from accept to result register: 2 squares, 32 root steps,
//   49 divider steps, 4 products, 12 coefficients; sample tick: tick add, phase check,
//   the 49-step phase divider and a horner multiply and add per coefficient; done tick: tick add and phase check
// one transaction in flight; the next is accepted in the cycle after the output register loads,
//   and a result waits to load while the output register is still full
// reset (synchronous, active high): idle, zero duration and elapsed time, configuration registers at defaults
module quintic_trajectory_generator_unit (
   input  logic          clock,
   input  logic          reset,
   // input channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [255:0]  req_tdata,  // begin_x, begin_y, end_x, end_y, start_vel_x,
                                     // start_vel_y, final_vel_x, final_vel_y
   input  logic          req_tuser,  // op
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,  // sample_x, sample_y
   output logic [1:0]    rsp_tuser,  // segment_done, coeff_saturated
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   // configuration registers: travel speed at 0x0, sample period at 0x4
   logic [30:0] speed_ff, period_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= qtg_pkg::SPEED_RESET;
         period_ff <= qtg_pkg::PERIOD_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == qtg_pkg::REG_SPEED) speed_ff  <= csr_pwdata[30:0];
         else                                    period_ff <= csr_pwdata[30:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == qtg_pkg::REG_PERIOD) ? {1'b0, period_ff}
                                                             : {1'b0, speed_ff};

   // sequencer and datapath talk only through the command and status bundles
   qtg_pkg::cmd_type    cmd;
   qtg_pkg::status_type status;

   qtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // holds segment state, shared multiplier, root and divider units, output register
   qtg_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .speed      (speed_ff),
      .period     (period_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`include "quintic_trajectory_generator_unit_assert.svh"

   // a done result carries no sample and no clip flag
   `QTG_ASSERT_IMP(a_done_clean, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1])
   // one transaction at a time: busy right after an accept
   `QTG_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // a result is only written into a free output register
   `QTG_ASSERT_IMP(a_emit_free, cmd.op == qtg_pkg::CMD_EMIT, status.out_free)

endmodule
